// ----- sv/mfbc_pkg.sv -----
// Shared constants, codes and the CRC-16 byte update for the Modbus frame builder/checker.
package mfbc_pkg;

  localparam int MAX_REGISTERS = 8;
  localparam int REG_W         = $clog2(MAX_REGISTERS + 1);
  localparam int POS_W         = $clog2(2 * MAX_REGISTERS + 5);

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;
  localparam logic [7:0]  SLAVE_RST  = 8'h5F;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RESP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_REQ     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_ECHO      = 3'd2,
    ST_BAD_CRC   = 3'd3,
    ST_CNT_RANGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_READ  = 2'd1,
    PEND_WRITE = 2'd2
  } pend_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_HDR  = 2'd1,
    FAULT_ECHO = 2'd2
  } fault_e;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  localparam logic [15:0] SEED_RST = crc_byte(CRC_INIT, SLAVE_RST);

endpackage

// ----- sv/modbus_frame_builder_checker_unit.sv -----
// Modbus RTU request framer and response checker, top level.
// A response byte is taken when in_valid_i and in_ready_o are high; its result, if any, appears
// in the output register in the cycle after, so response bytes stream at one per cycle while the
// output drains and no request is being sent. A read or write request is taken the same way; its
// seven bytes leave one per cycle while the output is not stalled, from a small emitter that
// folds the first five into the CRC; the next item can be taken once the seventh byte is loaded.
// A read with a register count of zero or above the limit gives one status item at once.
module modbus_frame_builder_checker_unit
  import mfbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] reg_address_i,
  input  logic [15:0] word_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  logic [15:0]      seed_q;
  pend_e            pend_q, pend_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [REG_W-1:0] exp_regs_q, exp_regs_d;
  logic [15:0]      exp_val_q, exp_val_d;
  logic [7:0]       echo_hi_q, echo_hi_d;
  fault_e           fault_q, fault_d;

  logic        tx_busy_q, tx_busy_d;
  logic [2:0]  tx_idx_q, tx_idx_d;
  logic        tx_read_q, tx_read_d;
  logic [15:0] tx_addr_q, tx_addr_d;
  logic [15:0] tx_word_q, tx_word_d;
  logic [15:0] tx_crc_q, tx_crc_d;

  logic       out_valid_q, out_valid_d;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  status_e    status_q, status_d;
  logic       last_q, last_d;

  logic             out_free, in_acc;
  logic [7:0]       tx_byte;
  logic [15:0]      rx_crc;
  logic [POS_W-1:0] total, pos_n;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !tx_busy_q && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  assign rx_crc = crc_byte(crc_q, data_byte_i);
  assign pos_n  = pos_q + POS_W'(1);
  assign total  = (pend_q == PEND_READ) ? (POS_W'(exp_regs_q) << 1) + POS_W'(4) : POS_W'(7);

  always_comb begin
    case (tx_idx_q)
      3'd0:    tx_byte = tx_read_q ? FUNC_READ : FUNC_WRITE;
      3'd1:    tx_byte = tx_addr_q[15:8];
      3'd2:    tx_byte = tx_addr_q[7:0];
      3'd3:    tx_byte = tx_word_q[15:8];
      3'd4:    tx_byte = tx_word_q[7:0];
      3'd5:    tx_byte = tx_crc_q[7:0];
      default: tx_byte = tx_crc_q[15:8];
    endcase
  end

  always_comb begin
    pend_d      = pend_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    exp_regs_d  = exp_regs_q;
    exp_val_d   = exp_val_q;
    echo_hi_d   = echo_hi_q;
    fault_d     = fault_q;
    tx_busy_d   = tx_busy_q;
    tx_idx_d    = tx_idx_q;
    tx_read_d   = tx_read_q;
    tx_addr_d   = tx_addr_q;
    tx_word_d   = tx_word_q;
    tx_crc_d    = tx_crc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    byte_d      = byte_q;
    status_d    = status_q;
    last_d      = last_q;

    if (tx_busy_q && out_free) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_REQ;
      byte_d      = tx_byte;
      status_d    = ST_OK;
      last_d      = (tx_idx_q == 3'd6);
      if (tx_idx_q < 3'd5) tx_crc_d = crc_byte(tx_crc_q, tx_byte);
      tx_idx_d = tx_idx_q + 3'd1;
      if (tx_idx_q == 3'd6) tx_busy_d = 1'b0;
    end

    if (in_acc) begin
      case (action_e'(action_i))
        ACT_READ, ACT_WRITE: begin
          if (action_e'(action_i) == ACT_READ &&
              (word_i == 16'd0 || word_i > 16'(MAX_REGISTERS))) begin
            pend_d      = PEND_NONE;
            out_valid_d = 1'b1;
            kind_d      = KIND_STATUS;
            byte_d      = 8'h00;
            status_d    = ST_CNT_RANGE;
            last_d      = 1'b1;
          end else begin
            pend_d     = (action_e'(action_i) == ACT_READ) ? PEND_READ : PEND_WRITE;
            exp_regs_d = (action_e'(action_i) == ACT_READ) ? word_i[REG_W-1:0] : '0;
            exp_val_d  = (action_e'(action_i) == ACT_WRITE) ? word_i : 16'h0000;
            echo_hi_d  = 8'h00;
            fault_d    = FAULT_NONE;
            pos_d      = '0;
            crc_d      = seed_q;
            tx_busy_d  = 1'b1;
            tx_idx_d   = 3'd0;
            tx_read_d  = (action_e'(action_i) == ACT_READ);
            tx_addr_d  = reg_address_i;
            tx_word_d  = word_i;
            tx_crc_d   = seed_q;
          end
        end
        ACT_RESP: begin
          if (pend_q != PEND_NONE) begin
            crc_d = rx_crc;
            pos_d = pos_n;
            if (pend_q == PEND_READ) begin
              if (pos_q == '0) begin
                if (data_byte_i != FUNC_READ) fault_d = FAULT_HDR;
              end else if (pos_q == POS_W'(1)) begin
                if (data_byte_i != 8'({exp_regs_q, 1'b0})) fault_d = FAULT_HDR;
              end else if (pos_q < total - POS_W'(2)) begin
                out_valid_d = 1'b1;
                kind_d      = KIND_PAYLOAD;
                byte_d      = data_byte_i;
                status_d    = ST_OK;
                last_d      = 1'b0;
              end
            end else begin
              if (pos_q == '0) begin
                if (data_byte_i != FUNC_WRITE) fault_d = FAULT_HDR;
              end else if (pos_q == POS_W'(3)) begin
                echo_hi_d = data_byte_i;
              end else if (pos_q == POS_W'(4)) begin
                if (fault_q == FAULT_NONE && {echo_hi_q, data_byte_i} != exp_val_q)
                  fault_d = FAULT_ECHO;
              end
            end
            if (pos_n >= total) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_STATUS;
              byte_d      = 8'h00;
              last_d      = 1'b1;
              pend_d      = PEND_NONE;
              if (fault_d == FAULT_HDR)       status_d = ST_BAD_HDR;
              else if (fault_d == FAULT_ECHO) status_d = ST_ECHO;
              else if (rx_crc != 16'h0000)    status_d = ST_BAD_CRC;
              else                            status_d = ST_OK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SEED_RST;
      pend_q      <= PEND_NONE;
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      exp_regs_q  <= '0;
      exp_val_q   <= 16'h0000;
      echo_hi_q   <= 8'h00;
      fault_q     <= FAULT_NONE;
      tx_busy_q   <= 1'b0;
      tx_idx_q    <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) seed_q <= crc_byte(CRC_INIT, cfg_wdata_i);
      pend_q      <= pend_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      exp_regs_q  <= exp_regs_d;
      exp_val_q   <= exp_val_d;
      echo_hi_q   <= echo_hi_d;
      fault_q     <= fault_d;
      tx_busy_q   <= tx_busy_d;
      tx_idx_q    <= tx_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_read_q <= tx_read_d;
    tx_addr_q <= tx_addr_d;
    tx_word_q <= tx_word_d;
    tx_crc_q  <= tx_crc_d;
    kind_q    <= kind_d;
    byte_q    <= byte_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign byte_value_o = byte_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

// ----- sv/mfbc_checker.sv -----
// Port-level assertions for the Modbus frame builder/checker, bound to the top level.
module mfbc_checker
  import mfbc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  action_i,
  input logic [15:0] word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  byte_value_o,
  input logic [2:0]  status_o,
  input logic        last_o
);

  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_STATUS |-> byte_value_o == 8'h00 && last_o)
    else $error("status item with nonzero byte or without last");

  a_data_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_REQ || kind_o == KIND_PAYLOAD) |-> status_o == ST_OK)
    else $error("request or payload item with nonzero status");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_READ && word_i == 16'd0
    |=> out_valid_o && kind_o == KIND_STATUS && status_o == ST_CNT_RANGE)
    else $error("zero register count did not give a range status");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_WRITE |=> !in_ready_o)
    else $error("item taken while request bytes are still going out");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_value_o) && $stable(kind_o))
    else $error("stalled output item changed");

endmodule

bind modbus_frame_builder_checker_unit mfbc_checker u_mfbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .action_i     (action_i),
  .word_i       (word_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .byte_value_o (byte_value_o),
  .status_o     (status_o),
  .last_o       (last_o)
);
